// ----- rtl/bcd_clock_display_scan_key_set_macros.svh -----
// assertion helpers for the clock block
`ifndef BCD_CLOCK_DISPLAY_SCAN_KEY_SET_MACROS_SVH
`define BCD_CLOCK_DISPLAY_SCAN_KEY_SET_MACROS_SVH

// checked on every clock edge while out of reset
`define BCDK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define BCDK_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/bcdk_pkg.sv -----
`default_nettype none

package bcdk_pkg;

    // index 0 = second units up to 5 = hour tens
    typedef logic [5:0][3:0] t_digits;

    // time update request for one tick
    typedef struct packed {
        logic       sec_tick;
        logic       apply;
        logic [5:0] frame;
    } t_adjust;

    localparam logic [5:0] KEY_ENTER = 6'b000001;
    localparam logic [5:0] KEY_ESC   = 6'b000010;
    localparam logic [5:0] KEY_RIGHT = 6'b000100;
    localparam logic [5:0] KEY_DOWN  = 6'b010000;
    localparam logic [5:0] KEY_LEFT  = 6'b100000;

    localparam logic [5:0] CMD_HOUR_UP   = KEY_ENTER | KEY_LEFT;
    localparam logic [5:0] CMD_MIN_UP    = KEY_ENTER | KEY_DOWN;
    localparam logic [5:0] CMD_SEC_UP    = KEY_ENTER | KEY_RIGHT;
    localparam logic [5:0] CMD_HOUR_DOWN = KEY_ESC | KEY_LEFT;
    localparam logic [5:0] CMD_MIN_DOWN  = KEY_ESC | KEY_DOWN;
    localparam logic [5:0] CMD_SEC_DOWN  = KEY_ESC | KEY_RIGHT;

    localparam logic [15:0] TPS_RESET = 16'd1024;
    // 23:55:41
    localparam t_digits TIME_RESET = {4'd2, 4'd3, 4'd5, 4'd5, 4'd4, 4'd1};

    function automatic logic [6:0] seg_lookup(input logic [3:0] digit);
        logic [6:0] seg;
        case (digit)
            4'd0: seg = 7'b0111111;
            4'd1: seg = 7'b0000110;
            4'd2: seg = 7'b1011011;
            4'd3: seg = 7'b1001111;
            4'd4: seg = 7'b1100110;
            4'd5: seg = 7'b1101101;
            4'd6: seg = 7'b1111101;
            4'd7: seg = 7'b0000111;
            4'd8: seg = 7'b1111111;
            4'd9: seg = 7'b1101111;
            default: seg = 7'b0000000;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bcd_clock_display_scan_key_set.sv -----
// 24-hour bcd clock with multiplexed display and scanned key set
// the display word of an accepted tick word is registered and presented from the next cycle
// throughput: one tick word per cycle; the output register is refilled in the
//   cycle it is drained, so only a stalled output holds the input off
// reset (i_rst_n low, synchronous): time 23:55:41, prescaler, scans and key
//   history cleared, ticks_per_second back to 1024, output empty
`default_nettype none

`include "bcd_clock_display_scan_key_set_macros.svh"

module bcd_clock_display_scan_key_set
    import bcdk_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [15:0] i_cfg_wr_data,      // ticks_per_second
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,     // [0] key_sense, [7:1] zero
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [5:0] digit_select, [12:6] segment_pattern, [16:13] second_units,
    // [20:17] second_tens, [24:21] minute_units, [28:25] minute_tens,
    // [32:29] hour_units, [36:33] hour_tens, [39:37] zero
    output logic [39:0] o_m_axis_tdata
);

    logic [15:0]     r_tps;
    logic [15:0]     r_prescale;
    t_digits         r_digits;
    logic [2:0]      r_scan_index;
    logic [5:0]      r_digit_strobe;
    logic [5:0]      r_key_scan_bit;
    logic [5:0]      r_key_frame;
    logic [2:0][5:0] r_key_hist;
    logic            r_out_valid;
    logic [39:0]     r_out_data;

    logic [15:0]     n_prescale;
    t_digits         n_digits;
    logic [5:0]      n_key_scan_bit;
    logic [5:0]      n_key_frame;
    logic [2:0][5:0] n_key_hist;
    logic [39:0]     n_out_data;

    logic            s_accept;
    logic [16:0]     cnt_inc;
    logic [5:0]      frame_or;
    logic            frame_eval;
    logic [3:0]      shown_digit;
    t_adjust         adj;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_comb begin
        cnt_inc      = {1'b0, r_prescale} + 17'd1;
        adj.sec_tick = (cnt_inc >= {1'b0, r_tps});
        n_prescale   = adj.sec_tick ? 16'(cnt_inc - {1'b0, r_tps}) : cnt_inc[15:0];

        frame_or   = r_key_frame | (i_s_axis_tdata[0] ? r_key_scan_bit : 6'd0);
        // a frame closes after the last scan phase; empty frames are ignored
        frame_eval = r_key_scan_bit[5] && (frame_or != 6'd0);
        adj.frame  = frame_or;
        adj.apply  = frame_eval && (frame_or != r_key_hist[0])
                     && (frame_or != r_key_hist[1]) && (frame_or != r_key_hist[2]);

        n_key_scan_bit = r_key_scan_bit[5] ? 6'd1 : {r_key_scan_bit[4:0], 1'b0};
        n_key_frame    = r_key_scan_bit[5] ? 6'd0 : frame_or;
        n_key_hist     = frame_eval ? {r_key_hist[1], r_key_hist[0], frame_or} : r_key_hist;
    end

    bcdk_time_next u_time_next (
        .i_digits (r_digits),
        .i_adj    (adj),
        .o_digits (n_digits)
    );

    always_comb begin
        shown_digit = (r_scan_index < 3'd6) ? n_digits[r_scan_index] : n_digits[0];
        n_out_data  = {3'b000, n_digits[5], n_digits[4], n_digits[3], n_digits[2],
                       n_digits[1], n_digits[0], seg_lookup(shown_digit),
                       r_digit_strobe};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps          <= TPS_RESET;
            r_prescale     <= '0;
            r_digits       <= TIME_RESET;
            r_scan_index   <= '0;
            r_digit_strobe <= 6'd1;
            r_key_scan_bit <= 6'd1;
            r_key_frame    <= '0;
            r_key_hist     <= '0;
            r_out_valid    <= 1'b0;
            r_out_data     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tps <= i_cfg_wr_data;
            end
            if (s_accept) begin
                r_prescale     <= n_prescale;
                r_digits       <= n_digits;
                r_key_scan_bit <= n_key_scan_bit;
                r_key_frame    <= n_key_frame;
                r_key_hist     <= n_key_hist;
                r_out_data     <= n_out_data;
                if (r_scan_index < 3'd5) begin
                    r_scan_index   <= r_scan_index + 3'd1;
                    r_digit_strobe <= {r_digit_strobe[4:0], 1'b0};
                end else begin
                    r_scan_index   <= '0;
                    r_digit_strobe <= 6'd1;
                end
            end
            if (s_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // display strobe tracks the scan index
    `BCDK_ASSERT(a_strobe_index, r_digit_strobe == (6'd1 << r_scan_index), "strobe/index mismatch")
    `BCDK_ASSERT(a_key_scan_onehot, $onehot(r_key_scan_bit), "key scan bit not one-hot")
    `BCDK_ASSERT(a_accept_fills, s_accept |=> r_out_valid, "accepted word not presented")
    `BCDK_ASSERT(a_hour_tens, r_digits[5] <= 4'd2, "hour tens out of range")

endmodule

`default_nettype wire

// ----- rtl/bcdk_time_next.sv -----
`default_nettype none

module bcdk_time_next
    import bcdk_pkg::*;
(
    input  wire t_digits i_digits,
    input  wire t_adjust i_adj,
    output t_digits      o_digits
);

    always_comb begin
        t_digits d;
        d = i_digits;

        // one second carry chain; units wrap at 10, tens at 6, and hour 24 wraps to 00:00:00
        if (i_adj.sec_tick) begin
            d[0] = d[0] + 4'd1;
            if (d[0] == 4'd10) begin
                d[0] = 4'd0;
                d[1] = d[1] + 4'd1;
            end
            if (d[1] == 4'd6) begin
                d[1] = 4'd0;
                d[2] = d[2] + 4'd1;
            end
            if (d[2] == 4'd10) begin
                d[2] = 4'd0;
                d[3] = d[3] + 4'd1;
            end
            if (d[3] == 4'd6) begin
                d[3] = 4'd0;
                d[4] = d[4] + 4'd1;
            end
            if (d[4] == 4'd10) begin
                d[4] = 4'd0;
                d[5] = d[5] + 4'd1;
            end
            if ((d[5] == 4'd2 && d[4] >= 4'd4) || d[5] >= 4'd3) begin
                d = '0;
            end
        end

        if (i_adj.apply) begin
            case (i_adj.frame)
                CMD_HOUR_UP: begin
                    if (d[4] < 4'd9) begin
                        d[4] = d[4] + 4'd1;
                    end else if (d[5] < 4'd1) begin
                        d[4] = 4'd0;
                        d[5] = d[5] + 4'd1;
                    end else if (d[5] == 4'd1) begin
                        d[4] = 4'd0;
                        d[5] = 4'd2;
                    end
                end
                CMD_MIN_UP: begin
                    if (d[2] < 4'd9) begin
                        d[2] = d[2] + 4'd1;
                    end else if (d[3] < 4'd6) begin
                        d[2] = 4'd0;
                        d[3] = d[3] + 4'd1;
                    end
                end
                CMD_SEC_UP: begin
                    if (d[0] < 4'd9) begin
                        d[0] = d[0] + 4'd1;
                    end else if (d[1] < 4'd6) begin
                        d[0] = 4'd0;
                        d[1] = d[1] + 4'd1;
                    end
                end
                CMD_HOUR_DOWN: begin
                    // at 00 hours the minute tens step down instead
                    if (d[4] > 4'd0) begin
                        d[4] = d[4] - 4'd1;
                    end else if (d[5] > 4'd0) begin
                        d[4] = 4'd9;
                        d[5] = d[5] - 4'd1;
                    end else if (d[3] > 4'd0) begin
                        d[3] = d[3] - 4'd1;
                    end
                end
                CMD_MIN_DOWN: begin
                    if (d[2] > 4'd0) begin
                        d[2] = d[2] - 4'd1;
                    end else if (d[3] > 4'd0) begin
                        d[2] = 4'd9;
                        d[3] = d[3] - 4'd1;
                    end else if (d[1] > 4'd0) begin
                        d[1] = d[1] - 4'd1;
                    end
                end
                CMD_SEC_DOWN: begin
                    if (d[0] > 4'd0) begin
                        d[0] = d[0] - 4'd1;
                    end
                end
                default: begin
                end
            endcase
        end

        o_digits = d;
    end

endmodule

`default_nettype wire

// ----- tb/clock_word_checker.sv -----
`timescale 1ns / 1ps

module clock_word_checker
    import bcdk_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [15:0] i_cfg_wr_data,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [7:0]  i_s_tdata,
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [39:0] i_m_tdata,
    output int          o_pending,
    output int          o_errors
);

    // same layout as the output word, lowest field last
    typedef struct packed {
        logic [2:0] pad;
        t_digits    digits;
        logic [6:0] seg;
        logic [5:0] sel;
    } disp_word_t;

    logic [15:0] tick_limit;
    logic [15:0] prescale;
    t_digits     clk_dig;
    logic [2:0]  disp_idx;
    logic [5:0]  disp_strobe;
    logic [5:0]  scan_bit;
    logic [5:0]  key_acc;
    logic [5:0]  seen_frames [3];

    disp_word_t  display_q [$];

    initial begin
        o_pending = 0;
        o_errors  = 0;
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t mismatch on %s: expected %0d got %0d", $realtime, what, want, got);
        o_errors = o_errors + 1;
    endtask

    function automatic logic [6:0] glyph(input logic [3:0] d);
        logic [6:0] g;
        case (d)
            4'd0: g = 7'h3F;
            4'd1: g = 7'h06;
            4'd2: g = 7'h5B;
            4'd3: g = 7'h4F;
            4'd4: g = 7'h66;
            4'd5: g = 7'h6D;
            4'd6: g = 7'h7D;
            4'd7: g = 7'h07;
            4'd8: g = 7'h7F;
            4'd9: g = 7'h6F;
            default: g = 7'h00;
        endcase
        return g;
    endfunction

    function automatic string digit_name(input int i);
        case (i)
            0: return "second_units";
            1: return "second_tens";
            2: return "minute_units";
            3: return "minute_tens";
            4: return "hour_units";
            default: return "hour_tens";
        endcase
    endfunction

    task automatic clear_clock();
        tick_limit  = TPS_RESET;
        prescale    = '0;
        clk_dig     = TIME_RESET;
        disp_idx    = '0;
        disp_strobe = 6'd1;
        scan_bit    = 6'd1;
        key_acc     = '0;
        for (int i = 0; i < 3; i++) seen_frames[i] = '0;
    endtask

    // each carry test looks at the digit as it stands, set digits carry late
    task automatic tick_second();
        clk_dig[0] = clk_dig[0] + 4'd1;
        if (clk_dig[0] == 4'd10) begin
            clk_dig[0] = '0;
            clk_dig[1] = clk_dig[1] + 4'd1;
        end
        if (clk_dig[1] == 4'd6) begin
            clk_dig[1] = '0;
            clk_dig[2] = clk_dig[2] + 4'd1;
        end
        if (clk_dig[2] == 4'd10) begin
            clk_dig[2] = '0;
            clk_dig[3] = clk_dig[3] + 4'd1;
        end
        if (clk_dig[3] == 4'd6) begin
            clk_dig[3] = '0;
            clk_dig[4] = clk_dig[4] + 4'd1;
        end
        if (clk_dig[4] == 4'd10) begin
            clk_dig[4] = '0;
            clk_dig[5] = clk_dig[5] + 4'd1;
        end
        if ((clk_dig[5] == 4'd2 && clk_dig[4] >= 4'd4) || clk_dig[5] >= 4'd3) begin
            clk_dig = '0;
        end
    endtask

    task automatic set_pair_up(input int u);
        if (clk_dig[u] < 4'd9) begin
            clk_dig[u] = clk_dig[u] + 4'd1;
        end else if (clk_dig[u+1] < 4'd6) begin
            clk_dig[u]   = '0;
            clk_dig[u+1] = clk_dig[u+1] + 4'd1;
        end
    endtask

    // at 00 the tens digit of the next lower pair steps down
    task automatic set_pair_down(input int u);
        if (clk_dig[u] > 4'd0) begin
            clk_dig[u] = clk_dig[u] - 4'd1;
        end else if (clk_dig[u+1] > 4'd0) begin
            clk_dig[u]   = 4'd9;
            clk_dig[u+1] = clk_dig[u+1] - 4'd1;
        end else if (clk_dig[u-1] > 4'd0) begin
            clk_dig[u-1] = clk_dig[u-1] - 4'd1;
        end
    endtask

    task automatic take_key_frame();
        logic [5:0] f;
        f = key_acc;
        if (f != seen_frames[0] && f != seen_frames[1] && f != seen_frames[2]) begin
            case (f)
                CMD_HOUR_UP: begin
                    if (clk_dig[4] < 4'd9) begin
                        clk_dig[4] = clk_dig[4] + 4'd1;
                    end else if (clk_dig[5] < 4'd2) begin
                        clk_dig[4] = '0;
                        clk_dig[5] = clk_dig[5] + 4'd1;
                    end
                end
                CMD_MIN_UP:    set_pair_up(2);
                CMD_SEC_UP:    set_pair_up(0);
                CMD_HOUR_DOWN: set_pair_down(4);
                CMD_MIN_DOWN:  set_pair_down(2);
                CMD_SEC_DOWN: begin
                    if (clk_dig[0] > 4'd0) clk_dig[0] = clk_dig[0] - 4'd1;
                end
                default: ;
            endcase
        end
        seen_frames[2] = seen_frames[1];
        seen_frames[1] = seen_frames[0];
        seen_frames[0] = f;
        key_acc        = '0;
    endtask

    task automatic predict_display(input logic key, output disp_word_t w);
        logic [16:0] nxt;
        logic [6:0]  nbit;
        nxt = {1'b0, prescale} + 17'd1;
        if (nxt >= {1'b0, tick_limit}) begin
            prescale = nxt[15:0] - tick_limit;
            tick_second();
        end else begin
            prescale = nxt[15:0];
        end

        if (key) key_acc = key_acc | scan_bit;
        nbit = {scan_bit, 1'b0};
        if (nbit >= 7'h40 || nbit == 7'h00) begin
            scan_bit = 6'd1;
            if (key_acc != '0) take_key_frame();
        end else begin
            scan_bit = nbit[5:0];
        end

        w.pad    = '0;
        w.digits = clk_dig;
        w.seg    = glyph(clk_dig[(disp_idx < 3'd6) ? disp_idx : 3'd0]);
        w.sel    = disp_strobe;

        if (disp_idx < 3'd5) begin
            disp_idx    = disp_idx + 3'd1;
            disp_strobe = {disp_strobe[4:0], 1'b0};
        end else begin
            disp_idx    = '0;
            disp_strobe = 6'd1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        disp_word_t want;
        disp_word_t got;
        if (!i_rst_n) begin
            clear_clock();
            display_q.delete();
        end else begin
            if (i_cfg_wr_en) tick_limit = i_cfg_wr_data;

            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (display_q.size() == 0) begin
                    report_mismatch("unexpected word", 0, int'(got));
                end else begin
                    want = display_q.pop_front();
                    if (got.sel !== want.sel)
                        report_mismatch("digit_select", want.sel, got.sel);
                    if (got.seg !== want.seg)
                        report_mismatch("segment_pattern", want.seg, got.seg);
                    for (int i = 0; i < 6; i++) begin
                        if (got.digits[i] !== want.digits[i])
                            report_mismatch(digit_name(i), want.digits[i], got.digits[i]);
                    end
                    if (got.pad !== want.pad)
                        report_mismatch("padding", want.pad, got.pad);
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                predict_display(i_s_tdata[0], want);
                display_q.push_back(want);
            end
        end
        o_pending <= display_q.size();
    end

endmodule

// ----- tb/bcd_clock_display_scan_key_set_tb.sv -----
`timescale 1ns / 1ps

module bcd_clock_display_scan_key_set_tb;
    import bcdk_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 240;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic [7:0]  s_tdata     = '0;
    logic        m_tready    = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [39:0] m_tdata;

    int          pending;
    int          errors;
    int          cycles      = 0;
    int          tx_pct      = 0;
    int          rx_pct      = 0;
    logic        hold_tog    = 1'b0;
    logic        hold_seen   = 1'b0;
    int          hold_left   = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    bcd_clock_display_scan_key_set dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    clock_word_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_pending     (pending),
        .o_errors      (errors)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("bcd_clock_display_scan_key_set_tb failed");
            $finish;
        end
    end

    // display side: random stalls, plus a long hold-off when toggled
    always @(posedge i_clk) begin
        if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(0, 99) >= rx_pct);
        end
    end

    task automatic send_tick(input logic key);
        while (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, key};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // one full scan of six ticks, bit n is the key of scan phase n
    task automatic send_frame(input logic [5:0] keys);
        for (int b = 0; b < 6; b++) send_tick(keys[b]);
    endtask

    function automatic logic [5:0] pick_frame();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            case ($urandom_range(0, 5))
                0: return CMD_HOUR_UP;
                1: return CMD_MIN_UP;
                2: return CMD_SEC_UP;
                3: return CMD_HOUR_DOWN;
                4: return CMD_MIN_DOWN;
                default: return CMD_SEC_DOWN;
            endcase
        end else if (r < 80) begin
            return 6'($urandom_range(1, 63));
        end else if (r < 92) begin
            return 6'd0;
        end else begin
            return 6'h3F;
        end
    endfunction

    function automatic logic [15:0] tps_for(input int ph);
        case (ph)
            0: return 16'd1;
            1: return 16'd0;
            2: return 16'd65535;
            3: return 16'd5;       // below the count left by the slow phase
            4: return 16'd2;
            5: return TPS_RESET;
            6: return 16'd3;
            7: return 16'd60;
            default: return 16'd1;
        endcase
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_tps(input logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // hour up from 23 lands on 24, all keys at once, minute down, second up
        send_frame(CMD_HOUR_UP);
        send_frame(6'h3F);
        send_frame(CMD_MIN_DOWN);
        send_frame(CMD_SEC_UP);

        for (int ph = 0; ph < 9; ph++) begin
            drain();
            write_tps(tps_for(ph));
            case (ph % 4)
                0: begin tx_pct = 0;  rx_pct <= 0;  end
                1: begin tx_pct = 53; rx_pct <= 0;  end
                2: begin tx_pct = 0;  rx_pct <= 53; end
                default: begin tx_pct = 31; rx_pct <= 31; end
            endcase
            if (ph == 0) hold_tog <= ~hold_tog;
            repeat (15) send_frame(pick_frame());
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (errors == 0) begin
            $display("bcd_clock_display_scan_key_set_tb passed");
        end else begin
            $display("bcd_clock_display_scan_key_set_tb failed");
        end
        $finish;
    end

endmodule
